// ===== rtl/crc16d_pkg.sv =====
`timescale 1ns / 1ps
// Package for the CRC-16 packet deframer: frame phase type, framing constants
// and the byte-wide CRC-16/XMODEM update. No dependencies.
package crc16d_pkg;

  localparam logic [7:0]  START_BYTE    = 8'h02;
  localparam logic [7:0]  END_BYTE      = 8'h03;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd50;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_CRC_BAD = 2'd1,
    ST_END_BAD = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_LEN     = 6'b000010,
    PH_PAYLOAD = 6'b000100,
    PH_CRC_HI  = 6'b001000,
    PH_CRC_LO  = 6'b010000,
    PH_END     = 6'b100000
  } phase_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/crc16_packet_deframer_top.sv =====
`timescale 1ns / 1ps
// CRC-16 packet deframer top level: input register, frame state, result register.
// Depends on crc16d_pkg.
//
//  channel | dir | handshake               | content
//  in_     | in  | in_tvalid / in_tready   | tdata rx byte, tuser mode
//  out_    | out | out_tvalid / out_tready | tdata payload or verdict, tuser kind, tlast
//  cfg_    | in  | cfg_valid / cfg_ready   | cfg_data timeout ticks
//
// One item per cycle unless the output stalls; the result enters the output register when the
// input fires. The frame state is updated in one pass between the input and result registers.
// Reset (rst_n low, synchronous) clears phase, timer, counters and CRC; timeout 50.
// A stalled output holds both registers; the input register still fills when empty.
module crc16_packet_deframer_top
  import crc16d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] data, [15:8] position, [23:16] frame_length,
                                  // [25:24] status, [31:26] zero
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_mode_r;
  logic        advance;
  logic        fire;

  logic [7:0]  timeout_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  timer_r, timer_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;

  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_data;
  logic [7:0]  res_pos;
  status_t     res_status;

  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_data_r;
  logic [7:0]  out_pos_r;
  logic [7:0]  out_len_r;
  status_t     out_status_r;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    phase_nxt  = phase_r;
    timer_nxt  = timer_r;
    len_nxt    = len_r;
    count_nxt  = count_r;
    crc_nxt    = crc_r;
    rcrc_nxt   = rcrc_r;
    res_valid  = 1'b0;
    res_kind   = KIND_PAYLOAD;
    res_data   = 8'h00;
    res_pos    = 8'h00;
    res_status = ST_GOOD;
    if (in_mode_r == MODE_TICK) begin
      if (timer_r != 8'h00) begin
        timer_nxt = timer_r - 8'd1;
      end else begin
        if (phase_r != PH_IDLE) begin
          res_valid  = 1'b1;
          res_kind   = KIND_VERDICT;
          res_status = ST_TIMEOUT;
        end
        phase_nxt = PH_IDLE;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (in_byte_r == START_BYTE) begin
            phase_nxt = PH_LEN;
            timer_nxt = timeout_r;
            count_nxt = 8'h00;
            len_nxt   = 8'h00;
            crc_nxt   = 16'h0000;
          end
        end
        PH_LEN: begin
          len_nxt   = in_byte_r;
          phase_nxt = (in_byte_r == 8'h00) ? PH_CRC_HI : PH_PAYLOAD;
          timer_nxt = timeout_r;
        end
        PH_PAYLOAD: begin
          res_valid = 1'b1;
          res_kind  = KIND_PAYLOAD;
          res_data  = in_byte_r;
          res_pos   = count_r;
          crc_nxt   = crc16_byte(crc_r, in_byte_r);
          count_nxt = count_r + 8'd1;
          if (count_nxt == len_r) begin
            phase_nxt = PH_CRC_HI;
          end
          timer_nxt = timeout_r;
        end
        PH_CRC_HI: begin
          rcrc_nxt  = {in_byte_r, rcrc_r[7:0]};
          phase_nxt = PH_CRC_LO;
          timer_nxt = timeout_r;
        end
        PH_CRC_LO: begin
          rcrc_nxt  = {rcrc_r[15:8], in_byte_r};
          phase_nxt = PH_END;
          timer_nxt = timeout_r;
        end
        PH_END: begin
          res_valid = 1'b1;
          res_kind  = KIND_VERDICT;
          if (in_byte_r != END_BYTE) begin
            res_status = ST_END_BAD;
          end else if (crc_r == rcrc_r) begin
            res_status = ST_GOOD;
          end else begin
            res_status = ST_CRC_BAD;
          end
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
      phase_r     <= PH_IDLE;
      timer_r     <= 8'h00;
      len_r       <= 8'h00;
      count_r     <= 8'h00;
      crc_r       <= 16'h0000;
      rcrc_r      <= 16'h0000;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= fire && res_valid;
      end
      if (fire) begin
        phase_r <= phase_nxt;
        timer_r <= timer_nxt;
        len_r   <= len_nxt;
        count_r <= count_nxt;
        crc_r   <= crc_nxt;
        rcrc_r  <= rcrc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_mode_r <= in_tuser;
    end
    if (fire) begin
      out_kind_r   <= res_kind;
      out_data_r   <= res_data;
      out_pos_r    <= res_pos;
      out_len_r    <= len_nxt;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_status_r, out_len_r, out_pos_r, out_data_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_kind_r;

  a_verdict_closes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && res_kind == KIND_VERDICT |=> phase_r == PH_IDLE)
    else $error("verdict did not return frame to idle");

  a_payload_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> count_r < len_r)
    else $error("payload offset reached declared length");

  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_PAYLOAD |-> out_status_r == ST_GOOD && !out_tlast)
    else $error("payload result carries verdict fields");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(phase_r) && $stable(crc_r))
    else $error("frame state moved while output stalled");

endmodule

// ===== tb/crc16_deframer_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the CRC-16 packet deframer: predicts payload and verdict results
// from every input and configuration transaction and compares them with the output.
// Depends on crc16d_pkg; holds crc16d_tb_pkg, which the stimulus also uses.
package crc16d_tb_pkg;

  function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? crc16d_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

endpackage

module crc16_deframer_checker
  import crc16d_pkg::*;
  import crc16d_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          results_owed
);

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] pos;
    logic [7:0] flen;
    status_t    status;
    logic       last;
  } deframe_out_t;

  phase_t       phase;
  logic [7:0]   tick_left;
  logic [7:0]   len_decl;
  logic [7:0]   pay_idx;
  logic [7:0]   reload_ticks;
  logic [15:0]  crc_acc;
  logic [15:0]  crc_rx;
  deframe_out_t owed_q[$];
  deframe_out_t got;
  deframe_out_t want;
  int           n_fail = 0;

  initial begin
    fail_count   = 0;
    results_owed = 0;
  end

  task automatic owe(input logic kind, input logic [7:0] data, input logic [7:0] pos,
                     input status_t st);
    owed_q.push_back('{kind: kind, data: data, pos: pos, flen: len_decl, status: st,
                       last: kind});
  endtask

  task automatic fold_input(input logic mode, input logic [7:0] b);
    if (mode == MODE_TICK) begin
      if (tick_left != 8'd0) begin
        tick_left = tick_left - 8'd1;
      end else begin
        if (phase != PH_IDLE) owe(KIND_VERDICT, 8'h00, 8'h00, ST_TIMEOUT);
        phase = PH_IDLE;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          if (b == START_BYTE) begin
            phase     = PH_LEN;
            tick_left = reload_ticks;
            pay_idx   = 8'd0;
            len_decl  = 8'd0;
            crc_acc   = 16'h0000;
          end
        end
        PH_LEN: begin
          len_decl  = b;
          phase     = (b == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
          tick_left = reload_ticks;
        end
        PH_PAYLOAD: begin
          owe(KIND_PAYLOAD, b, pay_idx, ST_GOOD);
          crc_acc   = crc_fold(crc_acc, b);
          pay_idx   = pay_idx + 8'd1;
          if (pay_idx == len_decl) phase = PH_CRC_HI;
          tick_left = reload_ticks;
        end
        PH_CRC_HI: begin
          crc_rx[15:8] = b;
          phase        = PH_CRC_LO;
          tick_left    = reload_ticks;
        end
        PH_CRC_LO: begin
          crc_rx[7:0] = b;
          phase       = PH_END;
          tick_left   = reload_ticks;
        end
        PH_END: begin
          if (b != END_BYTE) owe(KIND_VERDICT, 8'h00, 8'h00, ST_END_BAD);
          else if (crc_acc == crc_rx) owe(KIND_VERDICT, 8'h00, 8'h00, ST_GOOD);
          else owe(KIND_VERDICT, 8'h00, 8'h00, ST_CRC_BAD);
          phase = PH_IDLE;
        end
        default: phase = PH_IDLE;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase        = PH_IDLE;
      tick_left    = 8'd0;
      len_decl     = 8'd0;
      pay_idx      = 8'd0;
      crc_acc      = 16'h0000;
      crc_rx       = 16'h0000;
      reload_ticks = TIMEOUT_RESET;
      owed_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{kind: out_tuser, data: out_tdata[7:0], pos: out_tdata[15:8],
                flen: out_tdata[23:16], status: status_t'(out_tdata[25:24]),
                last: out_tlast};
        if (owed_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result kind %0d data %0d pos %0d len %0d status %0d last %0d",
                   $time, got.kind, got.data, got.pos, got.flen, got.status, got.last);
        end else begin
          want = owed_q.pop_front();
          if (got !== want || out_tdata[31:26] !== 6'd0) begin
            n_fail++;
            $display({"%0t: expected kind %0d data %0d pos %0d len %0d status %0d last %0d pad 0,",
                      " got kind %0d data %0d pos %0d len %0d status %0d last %0d pad %0d"},
                     $time, want.kind, want.data, want.pos, want.flen, want.status,
                     want.last, got.kind, got.data, got.pos, got.flen, got.status,
                     got.last, out_tdata[31:26]);
          end
        end
      end
      if (cfg_valid && cfg_ready) reload_ticks = cfg_data;
      if (in_tvalid && in_tready) fold_input(in_tuser, in_tdata);
    end
    fail_count   <= n_fail;
    results_owed <= owed_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for crc16_packet_deframer_top: clock, reset, framed byte and tick
// stimulus, output back-pressure and the verdict. Depends on crc16d_pkg and the checker.
module tb_top;
  import crc16d_pkg::*;
  import crc16d_tb_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  typedef enum {FLAW_NONE, FLAW_CRC, FLAW_END} frame_flaw_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = 8'h00;

  int          fail_count;
  int          results_owed;
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          sent       = 0;
  int          cycles     = 0;
  int          hold_left  = 0;
  logic        hold_tgl   = 1'b0;
  logic        hold_seen  = 1'b0;
  logic [7:0]  tmo_now    = TIMEOUT_RESET;
  logic [15:0] crc;

  crc16_packet_deframer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  crc16_deframer_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // hold off the output for a long stretch on each toggle request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_tgl != hold_seen) begin
      hold_seen  <= hold_tgl;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic offer(input logic mode, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic tick_burst(input int n);
    repeat (n) offer(MODE_TICK, 8'($urandom_range(255)));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [7:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    tmo_now   = v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input int len, input frame_flaw_t flaw, input bit may_abort);
    logic [7:0]  seq[$];
    logic [15:0] acc;
    logic [7:0]  b;
    int          cut;
    acc = 16'h0000;
    seq.push_back(START_BYTE);
    seq.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      seq.push_back(b);
      acc = crc_fold(acc, b);
    end
    if (flaw == FLAW_CRC) acc ^= 16'($urandom_range(1, 65535));
    seq.push_back(acc[15:8]);
    seq.push_back(acc[7:0]);
    if (flaw == FLAW_END) begin
      do b = 8'($urandom_range(255)); while (b == END_BYTE);
      seq.push_back(b);
    end else begin
      seq.push_back(END_BYTE);
    end
    cut = (may_abort && $urandom_range(19) == 0) ? $urandom_range(seq.size() - 1, 1) : -1;
    foreach (seq[i]) begin
      // let the timer run out and drop the rest of the frame
      if (i == cut) begin
        tick_burst(tmo_now + 1);
        return;
      end
      if (i > 0 && $urandom_range(9) == 0)
        tick_burst(($urandom_range(3) == 0 && tmo_now <= 16) ? tmo_now :
                   $urandom_range(tmo_now < 4 ? tmo_now : 4));
      offer(MODE_BYTE, seq[i]);
    end
  endtask

  task automatic run_phase(input int n_items);
    int          len;
    int          pick;
    frame_flaw_t flaw;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        pick = $urandom_range(99);
        len  = (pick < 70) ? $urandom_range(8) :
               (pick < 97) ? $urandom_range(9, 40) : $urandom_range(200, 255);
        pick = $urandom_range(99);
        flaw = (pick < 12) ? FLAW_CRC : (pick < 22) ? FLAW_END : FLAW_NONE;
        send_frame(len, flaw, 1'b1);
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 6)) offer(1'($urandom_range(1)), 8'($urandom_range(255)));
      end else begin
        offer(MODE_BYTE, START_BYTE);
        repeat ($urandom_range(3)) offer(MODE_BYTE, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    offer(MODE_BYTE, 8'hFF);
    offer(MODE_TICK, 8'h00);
    send_frame(1, FLAW_CRC, 1'b0);
    crc = crc_fold(crc_fold(16'h0000, 8'h00), 8'hFF);
    offer(MODE_BYTE, START_BYTE);
    offer(MODE_BYTE, 8'd2);
    offer(MODE_TICK, 8'hFF);
    offer(MODE_BYTE, 8'h00);
    offer(MODE_BYTE, 8'hFF);
    offer(MODE_BYTE, crc[15:8]);
    offer(MODE_BYTE, crc[7:0]);
    offer(MODE_BYTE, END_BYTE);
    send_frame(0, FLAW_NONE, 1'b0);
    send_frame(0, FLAW_END, 1'b0);
    set_timeout(8'd0);
    offer(MODE_BYTE, START_BYTE);
    offer(MODE_TICK, 8'h00);
    offer(MODE_TICK, 8'hFF);

    set_timeout(8'd255);
    hold_tgl <= ~hold_tgl;
    send_frame(255, FLAW_NONE, 1'b0);
    run_phase(80);

    set_timeout(8'd2);
    idle_pct = 63;
    run_phase(430);

    set_timeout(8'd1);
    idle_pct = 0;
    stall_pct <= 63;
    run_phase(430);

    set_timeout(8'($urandom_range(3, 255)));
    idle_pct = 16;
    stall_pct <= 16;
    run_phase(430);

    settle();
    if (fail_count == 0 && results_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
